@@ sv/tvb_pkg.sv @@
// shared types and constants for the transformed vertex bounding box core
package tvb_pkg;

    localparam int COEFF_W    = 16;
    localparam int ROW_W      = 3 * COEFF_W;
    localparam int VAL_W      = 32;
    localparam int AXES       = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int FIFO_DEPTH = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROW_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_Z   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Z = 3'd5;

    localparam logic [VAL_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
    localparam logic [VAL_W-1:0] VAL_MIN = 32'h8000_0000;

    // transform settings handed to the front end
    typedef struct packed {
        logic [AXES-1:0][ROW_W-1:0] row;
        logic [AXES-1:0][VAL_W-1:0] shift;
    } tvb_cfg_t;

    // one transformed vertex as it sits in the queue
    typedef struct packed {
        logic [AXES-1:0][VAL_W-1:0] pos;
        logic                       first;
        logic                       last;
    } tvb_vertex_t;

endpackage

@@ sv/transformed_vertex_bounding_box_core.sv @@
// top level of the transformed vertex bounding box core
// throughput: one vertex per cycle while s_tready is high, set by the fully pipelined
// multiply and sum stages
// a box waiting on m_tready holds the back end only when the next popped vertex is also last
// reset: identity matrix, zero translation, empty bounds, pipeline and queue emptied
// configuration writes are taken every cycle and should land only while the core is idle
module transformed_vertex_bounding_box_core
    import tvb_pkg::*;
#(
    parameter int COORD_WIDTH     = 24,
    parameter int COEFF_FRAC_BITS = 12
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,

    // configuration write port
    input  logic                                    cfg_we,
    input  logic [CFG_IDX_W-1:0]                    cfg_index,
    input  logic [ROW_W-1:0]                        cfg_data,

    // vertex request channel
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // coord_x, coord_y, coord_z, zero pad to whole bytes
    input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]      s_tdata,
    // first_vertex
    input  logic                                    s_tuser,
    input  logic                                    s_tlast,

    // box result channel
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // lo_x, lo_y, lo_z, hi_x, hi_y, hi_z
    output logic [2*AXES*VAL_W-1:0]                 m_tdata
);

    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    // 1.0 in the coefficient format, placed per row on the diagonal
    localparam logic [COEFF_W-1:0] COEFF_ONE = COEFF_W'(1) << COEFF_FRAC_BITS;
    localparam logic [ROW_W-1:0] ROW_X_RESET = {COEFF_ONE, {(2*COEFF_W){1'b0}}};
    localparam logic [ROW_W-1:0] ROW_Y_RESET = {{COEFF_W{1'b0}}, COEFF_ONE, {COEFF_W{1'b0}}};
    localparam logic [ROW_W-1:0] ROW_Z_RESET = {{(2*COEFF_W){1'b0}}, COEFF_ONE};

    tvb_cfg_t                       cfg_reg;
    logic [AXES-1:0][COORD_WIDTH-1:0] coord;

    logic                           front_valid;
    tvb_vertex_t                    front_vertex;
    logic [1:0]                     inflight;

    logic                           head_valid;
    tvb_vertex_t                    head_data;
    logic                           pop;
    logic [CNT_W-1:0]               fifo_count;
    logic [CNT_W:0]                 committed;

    // register file, writes to unused indexes fall through
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.row[0]   <= ROW_X_RESET;
            cfg_reg.row[1]   <= ROW_Y_RESET;
            cfg_reg.row[2]   <= ROW_Z_RESET;
            cfg_reg.shift    <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_ROW_X:   cfg_reg.row[0]   <= cfg_data;
                REG_ROW_Y:   cfg_reg.row[1]   <= cfg_data;
                REG_ROW_Z:   cfg_reg.row[2]   <= cfg_data;
                REG_SHIFT_X: cfg_reg.shift[0] <= cfg_data[VAL_W-1:0];
                REG_SHIFT_Y: cfg_reg.shift[1] <= cfg_data[VAL_W-1:0];
                REG_SHIFT_Z: cfg_reg.shift[2] <= cfg_data[VAL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // unpack the vertex from the low end of tdata
    always_comb begin
        for (int k = 0; k < AXES; k++) begin
            coord[k] = s_tdata[k*COORD_WIDTH +: COORD_WIDTH];
        end
    end

    // accept only when every request already in the pipe has a queue slot
    assign committed = {1'b0, fifo_count} + (CNT_W+1)'(inflight);
    assign s_tready  = (committed < (CNT_W+1)'(FIFO_DEPTH));

    tvb_front #(
        .COORD_WIDTH     (COORD_WIDTH),
        .COEFF_FRAC_BITS (COEFF_FRAC_BITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid && s_tready),
        .in_coord   (coord),
        .in_first   (s_tuser),
        .in_last    (s_tlast),
        .cfg        (cfg_reg),
        .out_valid  (front_valid),
        .out_vertex (front_vertex),
        .inflight   (inflight)
    );

    // queue decouples the transform pipe from the bounds update
    tvb_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (front_valid),
        .push_data  (front_vertex),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data),
        .count      (fifo_count)
    );

    // bounds update and output register
    tvb_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop),
        .box_valid  (m_tvalid),
        .box_data   (m_tdata),
        .box_ready  (m_tready)
    );

endmodule

@@ sv/tvb_front.sv @@
// front end: multiplies the vertex by the matrix, sums, shifts, translates and saturates
module tvb_front
    import tvb_pkg::*;
#(
    parameter int COORD_WIDTH     = 24,
    parameter int COEFF_FRAC_BITS = 12
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    input  logic [AXES-1:0][COORD_WIDTH-1:0]    in_coord,
    input  logic                                in_first,
    input  logic                                in_last,
    input  tvb_cfg_t                            cfg,
    output logic                                out_valid,
    output tvb_vertex_t                         out_vertex,
    output logic [1:0]                          inflight
);

    localparam int PROD_W = COORD_WIDTH + COEFF_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int ACC_W  = ((SUM_W > VAL_W) ? SUM_W : VAL_W) + 1;

    logic signed [PROD_W-1:0] prod_reg [AXES][AXES];
    logic signed [PROD_W-1:0] prod_next [AXES][AXES];
    logic                     s1_valid_reg;
    logic                     s1_first_reg;
    logic                     s1_last_reg;

    logic                     s2_valid_reg;
    tvb_vertex_t              s2_vertex_reg;
    tvb_vertex_t              s2_vertex_next;

    // stage 1: nine products, column k of each row scales coordinate k
    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            for (int k = 0; k < AXES; k++) begin
                prod_next[a][k] = $signed(in_coord[k])
                                * $signed(cfg.row[a][ROW_W-1-COEFF_W*k -: COEFF_W]);
            end
        end
    end

    // stage 2: sum, floor shift, translate, saturate
    always_comb begin
        logic signed [SUM_W-1:0] sum;
        logic signed [SUM_W-1:0] sum_sh;
        logic signed [ACC_W-1:0] acc;
        sum    = '0;
        sum_sh = '0;
        acc    = '0;
        s2_vertex_next = '0;
        for (int a = 0; a < AXES; a++) begin
            sum = SUM_W'(prod_reg[a][0]) + SUM_W'(prod_reg[a][1]) + SUM_W'(prod_reg[a][2]);
            sum_sh = sum >>> COEFF_FRAC_BITS;
            acc = $signed({{(ACC_W-SUM_W){sum_sh[SUM_W-1]}}, sum_sh})
                + $signed({{(ACC_W-VAL_W){cfg.shift[a][VAL_W-1]}}, cfg.shift[a]});
            if (acc[ACC_W-1:VAL_W-1] == '0 || acc[ACC_W-1:VAL_W-1] == '1) begin
                s2_vertex_next.pos[a] = acc[VAL_W-1:0];
            end else if (acc[ACC_W-1]) begin
                s2_vertex_next.pos[a] = VAL_MIN;
            end else begin
                s2_vertex_next.pos[a] = VAL_MAX;
            end
        end
        s2_vertex_next.first = s1_first_reg;
        s2_vertex_next.last  = s1_last_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg      <= prod_next;
        s1_first_reg  <= in_first;
        s1_last_reg   <= in_last;
        s2_vertex_reg <= s2_vertex_next;
    end

    assign out_valid  = s2_valid_reg;
    assign out_vertex = s2_vertex_reg;
    assign inflight   = {1'b0, s1_valid_reg} + {1'b0, s2_valid_reg};

endmodule

@@ sv/tvb_fifo.sv @@
// short queue of transformed vertices between front and back end
module tvb_fifo
    import tvb_pkg::*;
(
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              push,
    input  tvb_vertex_t                       push_data,
    input  logic                              pop,
    output logic                              head_valid,
    output tvb_vertex_t                       head_data,
    output logic [$clog2(FIFO_DEPTH+1)-1:0]   count
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    tvb_vertex_t        mem [FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    assign head_valid = (count_reg != '0);
    assign head_data  = mem[rd_ptr_reg];
    assign count      = count_reg;

endmodule

@@ sv/tvb_back.sv @@
// back end: running per-axis min and max, box output register
module tvb_back
    import tvb_pkg::*;
(
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          head_valid,
    input  tvb_vertex_t                   head_data,
    output logic                          pop,
    output logic                          box_valid,
    output logic [2*AXES*VAL_W-1:0]       box_data,
    input  logic                          box_ready
);

    logic [AXES-1:0][VAL_W-1:0] min_reg;
    logic [AXES-1:0][VAL_W-1:0] min_next;
    logic [AXES-1:0][VAL_W-1:0] max_reg;
    logic [AXES-1:0][VAL_W-1:0] max_next;
    logic                       box_valid_reg;
    logic [2*AXES*VAL_W-1:0]    box_reg;

    // a vertex that emits a box waits until the output slot is free
    assign pop = head_valid && (!head_data.last || !box_valid_reg || box_ready);

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            if (head_data.first || $signed(head_data.pos[a]) < $signed(min_reg[a])) begin
                min_next[a] = head_data.pos[a];
            end else begin
                min_next[a] = min_reg[a];
            end
            if (head_data.first || $signed(head_data.pos[a]) > $signed(max_reg[a])) begin
                max_next[a] = head_data.pos[a];
            end else begin
                max_next[a] = max_reg[a];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg       <= {AXES{VAL_MAX}};
            max_reg       <= {AXES{VAL_MIN}};
            box_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                min_reg <= min_next;
                max_reg <= max_next;
            end
            if (pop && head_data.last) begin
                box_valid_reg <= 1'b1;
            end else if (box_ready) begin
                box_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && head_data.last) begin
            box_reg <= {max_next, min_next};
        end
    end

    assign box_valid = box_valid_reg;
    assign box_data  = box_reg;

endmodule

@@ dv/tb_transformed_vertex_bounding_box_core.sv @@
// self-checking testbench for the transformed vertex bounding box core, with box predictor
module tb_transformed_vertex_bounding_box_core;
    import tvb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_W    = 24;
    localparam int COEFF_FRAC = 12;
    localparam int DATA_W     = ((3 * COORD_W + 7) / 8) * 8;
    localparam int STALL_MAX  = 4000;   // cycles with no request or box moving
    localparam int HOLD_LEN   = 250;    // long receiver back-pressure stretch
    localparam int DRAIN_WAIT = 12;     // margin for vertices still in the pipe to reach the back end

    // indexes past the register file, writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam logic [COEFF_W-1:0] COEFF_ONE = 16'h1000;
    localparam logic [COEFF_W-1:0] COEFF_MAX = 16'h7FFF;
    localparam logic [COEFF_W-1:0] COEFF_MIN = 16'h8000;
    localparam logic [COORD_W-1:0] COORD_MAX = 24'h7F_FFFF;
    localparam logic [COORD_W-1:0] COORD_MIN = 24'h80_0000;

    // coordinate triple as packed in s_tdata, index 0 is x in the low bits
    typedef logic [AXES-1:0][COORD_W-1:0] coords_t;
    // box as packed in m_tdata: lo x, lo y, lo z, hi x, hi y, hi z from the low bits
    typedef logic [2*AXES-1:0][VAL_W-1:0] box_t;

    // running transform and bounds, plus the boxes still owed by the core
    class box_scoreboard;
        logic [ROW_W-1:0]        row   [AXES];
        logic signed [VAL_W-1:0] shift [AXES];
        logic signed [VAL_W-1:0] lo    [AXES];
        logic signed [VAL_W-1:0] hi    [AXES];
        box_t                    boxes [$];
        int                      errors;
        int                      box_count;

        function new();
            row[0] = {COEFF_ONE, 16'h0, 16'h0};
            row[1] = {16'h0, COEFF_ONE, 16'h0};
            row[2] = {16'h0, 16'h0, COEFF_ONE};
            foreach (shift[a]) shift[a] = '0;
            restart_bounds();
            errors    = 0;
            box_count = 0;
        endfunction

        function void restart_bounds();
            foreach (lo[a]) begin
                lo[a] = VAL_MAX;
                hi[a] = VAL_MIN;
            end
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [ROW_W-1:0] data);
            case (idx)
                REG_ROW_X, REG_ROW_Y, REG_ROW_Z: row[idx] = data;
                REG_SHIFT_X: shift[0] = data[VAL_W-1:0];
                REG_SHIFT_Y: shift[1] = data[VAL_W-1:0];
                REG_SHIFT_Z: shift[2] = data[VAL_W-1:0];
                default: ;
            endcase
        endfunction

        // exact dot product, floor shift, translation, then clamp to 32 bits
        function logic signed [VAL_W-1:0] map_axis(int a, coords_t v);
            longint sum;
            longint cv;
            longint co;
            longint t;
            sum = 0;
            for (int k = 0; k < AXES; k++) begin
                cv = $signed(v[k]);
                co = $signed(row[a][32-16*k +: 16]);
                sum += cv * co;
            end
            t = (sum >>> COEFF_FRAC) + shift[a];
            if (t > 64'sh7FFF_FFFF)
                t = 64'sh7FFF_FFFF;
            else if (t < -64'sh8000_0000)
                t = -64'sh8000_0000;
            return t[VAL_W-1:0];
        endfunction

        function void note_vertex(coords_t v, logic first, logic last);
            logic signed [VAL_W-1:0] p;
            box_t b;
            if (first)
                restart_bounds();
            for (int a = 0; a < AXES; a++) begin
                p = map_axis(a, v);
                if (p < lo[a]) lo[a] = p;
                if (p > hi[a]) hi[a] = p;
            end
            if (last) begin
                for (int a = 0; a < AXES; a++) begin
                    b[a]        = lo[a];
                    b[AXES + a] = hi[a];
                end
                boxes.push_back(b);
            end
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at box %0d: %s", box_count, msg);
            errors++;
        endtask

        task check_box(box_t got);
            box_t want;
            string fname [2*AXES];
            fname = '{"lo_x", "lo_y", "lo_z", "hi_x", "hi_y", "hi_z"};
            if (boxes.size() == 0) begin
                report_mismatch($sformatf("box %h with no frame closed", got));
            end else begin
                want = boxes.pop_front();
                for (int f = 0; f < 2 * AXES; f++) begin
                    if (got[f] !== want[f])
                        report_mismatch($sformatf("%s got %h expected %h",
                                                  fname[f], got[f], want[f]));
                end
            end
            box_count++;
        endtask
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ROW_W-1:0]     cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [DATA_W-1:0]    s_tdata;
    logic                 s_tuser;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [2*AXES*VAL_W-1:0] m_tdata;

    box_scoreboard sb;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    logic hold_req = 1'b0;
    int   hold_left = HOLD_LEN;
    int   stall_cycles = 0;

    always #6 aclk = ~aclk;

    transformed_vertex_bounding_box_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // box receiver: check on every handshake, then pick the next ready
    // a single long hold-off lets the core fill up and stall the vertex side
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_box(m_tdata);
        if (hold_req && hold_left != 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog: too long without any request or box moving means a hang
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_MAX) begin
            $display("timeout: nothing moved for %0d cycles", STALL_MAX);
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [COORD_W-1:0] rand_coord();
        case ($urandom_range(9))
            0: return COORD_MAX;
            1: return COORD_MIN;
            2, 3, 4: return COORD_W'($urandom_range(8191)) - 24'd4096;
            default: return COORD_W'($urandom());
        endcase
    endfunction

    // one register write, the enable stays up for back-to-back writes
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [ROW_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        sb.write_reg(idx, val);
    endtask

    // full transform load; junk in the unused upper bits and in the spare indexes
    task automatic load_transform(input logic [ROW_W-1:0] rx, ry, rz,
                                  input logic [VAL_W-1:0] tx, ty, tz);
        cfg_write(REG_ROW_X, rx);
        cfg_write(REG_ROW_Y, ry);
        cfg_write(REG_ROW_Z, rz);
        cfg_write(REG_SHIFT_X, {16'($urandom()), tx});
        cfg_write(REG_SHIFT_Y, {16'($urandom()), ty});
        cfg_write(REG_SHIFT_Z, {16'($urandom()), tz});
        cfg_write(REG_SPARE_LO, ROW_W'({$urandom(), $urandom()}));
        cfg_write(REG_SPARE_HI, ROW_W'({$urandom(), $urandom()}));
        cfg_we <= 1'b0;
    endtask

    task automatic random_transform();
        logic [VAL_W-1:0] t [AXES];
        foreach (t[a]) begin
            if ($urandom_range(3) == 0)
                t[a] = $urandom();
            else
                t[a] = VAL_W'($urandom_range(65535)) - 32'd32768;
        end
        load_transform(ROW_W'({$urandom(), $urandom()}), ROW_W'({$urandom(), $urandom()}),
                       ROW_W'({$urandom(), $urandom()}), t[0], t[1], t[2]);
    endtask

    // offer one vertex request and hold it until the core takes it
    task automatic send_vertex(input logic [COORD_W-1:0] x, y, z, input logic first, last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {z, y, x};
        s_tuser  <= first;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        sb.note_vertex({z, y, x}, first, last);
    endtask

    task automatic send_frame(input int len, input bit open, input bit close);
        for (int i = 0; i < len; i++)
            send_vertex(rand_coord(), rand_coord(), rand_coord(),
                        open && i == 0, close && i == len - 1);
    endtask

    // before touching the transform: no box owed, and pipeline emptied of open frames
    task automatic wait_core_idle();
        s_tvalid <= 1'b0;
        while (sb.boxes.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    initial begin
        int sent;
        int len;
        sb = new();
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_ROW_X;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        s_tlast   <= 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset transform is identity; first box comes with no first flag since reset
        send_vertex(24'd1, 24'd2, 24'd3, 1'b0, 1'b1);
        send_vertex(COORD_MAX, COORD_MIN, 24'd0, 1'b1, 1'b0);
        send_vertex(COORD_MIN, COORD_MAX, 24'hFF_FFFF, 1'b0, 1'b1);
        // bounds survive the emit and keep growing
        send_vertex(24'h100, 24'h100, 24'h100, 1'b0, 1'b1);
        // first and last on one vertex
        send_vertex(24'd5, -24'sd5, 24'd0, 1'b1, 1'b1);

        // largest coefficients and translation, pushes into positive clamp
        wait_core_idle();
        load_transform({3{COEFF_MAX}}, {3{COEFF_MAX}}, {3{COEFF_MAX}},
                       VAL_MAX, VAL_MAX, VAL_MAX);
        send_vertex(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1, 1'b1);
        send_vertex(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1, 1'b0);
        send_vertex(24'd0, 24'd0, 24'd0, 1'b0, 1'b1);

        // most negative coefficients and translation, pushes into negative clamp
        wait_core_idle();
        load_transform({3{COEFF_MIN}}, {3{COEFF_MIN}}, {3{COEFF_MIN}},
                       VAL_MIN, VAL_MIN, VAL_MIN);
        send_vertex(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1, 1'b1);
        send_vertex(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1, 1'b1);

        // tiny coefficient: the shift rounds toward minus infinity
        wait_core_idle();
        load_transform({16'd1, 16'd0, 16'd0}, {16'd0, 16'd1, 16'd0}, {16'd0, 16'd0, 16'd1},
                       '0, '0, '0);
        send_vertex(-24'sd1, -24'sd1, -24'sd1, 1'b1, 1'b0);
        send_vertex(24'd1, 24'd4097, -24'sd4097, 1'b0, 1'b1);

        // axes swapped with a translation, then an all-zero matrix
        wait_core_idle();
        load_transform({16'd0, 16'd0, COEFF_ONE}, {COEFF_ONE, 16'd0, 16'd0},
                       {16'd0, COEFF_ONE, 16'd0}, -32'sd256, 32'd512, 32'd1);
        send_frame(3, 1'b1, 1'b1);
        wait_core_idle();
        load_transform('0, '0, '0, 32'h1234_5678, 32'hFEDC_BA98, '0);
        send_frame(2, 1'b1, 1'b1);

        // random frames under three idling patterns, three transforms each
        for (int p = 0; p < 3; p++) begin
            case (p)
                0: begin send_idle_pct = 28; recv_idle_pct = 71; end
                1: begin send_idle_pct = 71; recv_idle_pct = 28; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (int s = 0; s < 3; s++) begin
                wait_core_idle();
                random_transform();
                if (p == 1 && s == 1) begin
                    // receiver stops for a long stretch while single-vertex boxes pile up
                    send_idle_pct = 0;
                    hold_req <= 1'b1;
                    repeat (30) send_frame(1, 1'b1, 1'b1);
                    send_idle_pct = 71;
                end
                sent = 0;
                while (sent < 42) begin
                    len = ($urandom_range(9) == 0) ? 12 : $urandom_range(1, 6);
                    case ($urandom_range(19))
                        0, 1: send_frame(len, 1'b0, 1'b1);      // keeps old bounds
                        2, 3: send_frame(len, 1'b1, 1'b0);      // frame left open
                        4: begin
                            len = 1;
                            send_vertex(rand_coord(), rand_coord(), rand_coord(),
                                        1'($urandom()), 1'($urandom()));
                        end
                        default: send_frame(len, 1'b1, 1'b1);
                    endcase
                    sent += len;
                end
            end
        end

        // drain, then give stray boxes time to show up
        s_tvalid <= 1'b0;
        while (sb.boxes.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (sb.errors == 0 && sb.boxes.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/tvb_pkg.sv
sv/tvb_front.sv
sv/tvb_fifo.sv
sv/tvb_back.sv
sv/transformed_vertex_bounding_box_core.sv
dv/tb_transformed_vertex_bounding_box_core.sv
